// ===== rtl/hz_gb_stream_decoder_top_defines.svh =====
// Assertion macros shared by the HZ/GB stream decoder RTL.
`ifndef HZ_GB_STREAM_DECODER_TOP_DEFINES_SVH
`define HZ_GB_STREAM_DECODER_TOP_DEFINES_SVH

// Property that must hold in the same cycle whenever the antecedent is true.
`define HZGB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent is true.
`define HZGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hzgb_pkg.sv =====
// Constants shared by the HZ/GB stream decoder.
`default_nettype none

package hzgb_pkg;

  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_GB    = 2'd1;
  localparam logic [1:0] KIND_NOMAP = 2'd2;

  localparam logic [7:0] ESC_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_TO_GB    = 8'h7B;
  localparam logic [7:0] ESC_TO_ASCII = 8'h7D;
  localparam logic [7:0] ESC_NEWLINE  = 8'h0A;

  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] LEAD_MIN  = 8'h81;
  localparam logic [7:0] TRAIL_MIN = 8'h40;
  localparam logic [7:0] BYTE_MAX  = 8'hFE;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/hz_gb_stream_decoder_top.sv =====
// HZ/GB byte stream decoder: one byte in, at most one character code out.
// Decode results are registered in the output register, or in the skid register behind it.
// Throughput: one input byte per cycle while in_stall is low, set by the single decode stage.
// A skid register takes a result while the output register is stalled, so input stalls only
// once both are full. Synchronous reset returns to ASCII mode with no held byte and no output.
`default_nettype none
`include "hz_gb_stream_decoder_top_defines.svh"

module hz_gb_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_value
);

  logic       gb_mode;
  logic       gb_mode_next;
  logic       pending_valid;
  logic       pending_valid_next;
  logic [7:0] pending_byte;
  logic       run_nonempty;
  logic       run_nonempty_next;

  logic                 res_valid;
  hzgb_pkg::result_t    res;
  logic                 skid_valid;
  hzgb_pkg::result_t    skid;

  logic accept;
  logic out_free;
  logic gb_pair_ok;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign gb_pair_ok = (pending_byte >= hzgb_pkg::LEAD_MIN) && (pending_byte <= hzgb_pkg::BYTE_MAX)
                      && (in_byte >= hzgb_pkg::TRAIL_MIN) && (in_byte <= hzgb_pkg::BYTE_MAX);

  always_comb begin
    gb_mode_next       = gb_mode;
    pending_valid_next = pending_valid;
    run_nonempty_next  = run_nonempty;
    res_valid          = 1'b0;
    res.kind           = hzgb_pkg::KIND_NOMAP;
    res.value          = 16'd0;
    if (accept) begin
      if (!pending_valid) begin
        if (in_byte[7] || (in_byte == hzgb_pkg::ESC_BYTE) || gb_mode) begin
          pending_valid_next = 1'b1;
        end else begin
          res_valid = 1'b1;
          res.kind  = hzgb_pkg::KIND_ASCII;
          res.value = {8'd0, in_byte};
        end
      end else begin
        // The held byte is always released here.
        pending_valid_next = 1'b0;
        if (pending_byte[7]) begin
          res_valid = 1'b1;
          if (gb_pair_ok) begin
            res.kind  = hzgb_pkg::KIND_GB;
            res.value = {pending_byte, in_byte};
          end
        end else if (pending_byte == hzgb_pkg::ESC_BYTE) begin
          unique case (in_byte)
            hzgb_pkg::ESC_TO_GB: begin
              gb_mode_next      = 1'b1;
              run_nonempty_next = 1'b0;
            end
            hzgb_pkg::ESC_TO_ASCII: begin
              gb_mode_next      = 1'b0;
              // An empty GB run is flagged with a no-mapping marker.
              res_valid         = !run_nonempty;
              run_nonempty_next = 1'b0;
            end
            hzgb_pkg::ESC_BYTE: begin
              res_valid         = 1'b1;
              res.kind          = hzgb_pkg::KIND_ASCII;
              res.value         = {8'd0, hzgb_pkg::ESC_BYTE};
              run_nonempty_next = 1'b1;
            end
            hzgb_pkg::ESC_NEWLINE: begin
              res_valid = 1'b0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end else if (gb_mode) begin
          res_valid         = 1'b1;
          res.kind          = hzgb_pkg::KIND_GB;
          res.value         = {pending_byte | hzgb_pkg::HIGH_BIT, in_byte | hzgb_pkg::HIGH_BIT};
          run_nonempty_next = 1'b1;
        end else begin
          res_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gb_mode       <= 1'b0;
      pending_valid <= 1'b0;
      run_nonempty  <= 1'b0;
    end else begin
      gb_mode       <= gb_mode_next;
      pending_valid <= pending_valid_next;
      run_nonempty  <= run_nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !pending_valid) begin
      pending_byte <= in_byte;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_kind  <= skid.kind;
        out_value <= skid.value;
      end else if (res_valid) begin
        out_kind  <= res.kind;
        out_value <= res.value;
      end
    end else if (res_valid) begin
      skid <= res;
    end
  end

  `HZGB_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid register holds a request while the output register is empty")
  `HZGB_ASSERT_NOW(a_nomap_zero, clk, rst, out_valid && (out_kind == hzgb_pkg::KIND_NOMAP),
    out_value == 16'd0, "no-mapping marker carries a nonzero value")
  `HZGB_ASSERT_NOW(a_ascii_narrow, clk, rst, out_valid && (out_kind == hzgb_pkg::KIND_ASCII),
    out_value[15:7] == 9'd0, "ASCII result is wider than seven bits")
  `HZGB_ASSERT_NEXT(a_lead_held, clk, rst,
    accept && !pending_valid && (in_byte[7] || (in_byte == hzgb_pkg::ESC_BYTE)),
    pending_valid, "lead or escape byte was not held")

endmodule

`default_nettype wire
